// File: sv/lprt_pkg.sv
`timescale 1ns / 1ps

package lprt_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned SlotW = 3;
  localparam int unsigned LenW  = 6;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Lookup transaction as it travels down the row of route cells.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] dest;
    logic             found;
    logic [SlotW-1:0] slot;
    logic [LenW-1:0]  len;
  } lprt_token_t;

  // Entry written into one cell on an accepted insert.
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] mask;
    logic [LenW-1:0]  len;
  } lprt_wr_t;

endpackage

// File: sv/lprt_cell.sv
`timescale 1ns / 1ps

module lprt_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  lprt_pkg::lprt_wr_t   wr_i,
  input  logic                 in_use_i,
  input  lprt_pkg::lprt_token_t tok_i,
  output lprt_pkg::lprt_token_t tok_o
);

  localparam logic [lprt_pkg::SlotW-1:0] SlotCode = lprt_pkg::SlotW'(Index % 8);

  logic [lprt_pkg::AddrW-1:0] addr_q;
  logic [lprt_pkg::AddrW-1:0] mask_q;
  logic [lprt_pkg::LenW-1:0]  len_q;

  lprt_pkg::lprt_token_t tok_d;
  lprt_pkg::lprt_token_t tok_q;
  logic                  hit;

  // Entry storage has no reset; the cell only takes part once written.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      addr_q <= wr_i.addr;
      mask_q <= wr_i.mask;
      len_q  <= wr_i.len;
    end
  end

  assign hit = in_use_i && (((tok_i.dest ^ addr_q) & mask_q) == '0);

  // Only a strictly longer prefix replaces the earlier winner.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && hit && (!tok_i.found || (len_q > tok_i.len))) begin
      tok_d.found = 1'b1;
      tok_d.slot  = SlotCode;
      tok_d.len   = len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: sv/longest_prefix_route_table_core.sv
`timescale 1ns / 1ps

// Longest prefix route table. Each entry lives in one cell of a row of
// MAX_INTERFACES route cells. An insert transaction writes the next free cell
// and its result appears on the cycle after it is accepted, so inserts can
// be issued every cycle while no lookup is inside the row. A lookup
// transaction enters the first cell and moves one cell per cycle, carrying
// the best match so far; its result appears as it leaves the last cell.
// busy is high while a lookup is still inside the row, and the next
// transaction is taken in the same cycle in which the lookup result is shown.
// Each result is shown on done_o for exactly one cycle and cannot be stalled,
// so the receiver must take it then. Masks are counted bit by bit, so
// non-contiguous masks are legal, and on equal prefix length the entry that
// was inserted first wins. An insert into a full table leaves the table
// untouched and reports status 1.

module longest_prefix_route_table_core #(
  parameter int unsigned MAX_INTERFACES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] mask_i,
  output logic        done_o,
  output logic        matched_o,
  output logic [2:0]  slot_o,
  output logic [5:0]  prefix_length_o,
  output logic        status_o
);

  localparam int unsigned CntW = $clog2(MAX_INTERFACES + 1);
  localparam int unsigned IdxW = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_INTERFACES);

  // Population count as eight nibble counts added together.
  function automatic logic [lprt_pkg::LenW-1:0] popcount32(
    input logic [lprt_pkg::AddrW-1:0] v
  );
    logic [lprt_pkg::LenW-1:0] sum;
    logic [2:0]                nib;
    sum = '0;
    for (int n = 0; n < 8; n++) begin
      nib = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
      sum = sum + lprt_pkg::LenW'(nib);
    end
    return sum;
  endfunction

  logic                  accept;
  logic                  ins_accept;
  logic                  ins_ok;
  logic [CntW-1:0]       count_d;
  logic [CntW-1:0]       count_q;
  lprt_pkg::lprt_wr_t    wr;
  logic [MAX_INTERFACES-1:0] wr_en;
  logic [MAX_INTERFACES-1:0] in_use;
  logic [MAX_INTERFACES-1:0] pend_v;
  lprt_pkg::lprt_token_t chain [MAX_INTERFACES+1];
  lprt_pkg::lprt_token_t tail;

  logic                        ins_valid_q;
  logic [lprt_pkg::SlotW-1:0]  ins_slot_q;
  logic [lprt_pkg::LenW-1:0]   ins_len_q;
  logic                        ins_status_q;
  logic [lprt_pkg::SlotW-1:0]  ins_slot_d;
  logic [lprt_pkg::LenW-1:0]   ins_len_d;
  logic                        ins_status_d;

  assign accept     = start && !busy;
  assign ins_accept = accept && (mode_i == lprt_pkg::MODE_INSERT);
  assign ins_ok     = count_q < CntMax;

  // The entry is written straight into the cell picked by the fill count.
  assign wr.addr = address_i;
  assign wr.mask = mask_i;
  assign wr.len  = popcount32(mask_i);

  // A new lookup enters the first cell with no match yet.
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = accept && (mode_i == lprt_pkg::MODE_LOOKUP);
    chain[0].dest  = address_i;
  end

  for (genvar i = 0; i < MAX_INTERFACES; i++) begin : g_cell
    assign wr_en[i]  = ins_accept && ins_ok && (count_q[IdxW-1:0] == IdxW'(i));
    assign in_use[i] = CntW'(i) < count_q;

    lprt_cell #(
      .Index (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en[i]),
      .wr_i     (wr),
      .in_use_i (in_use[i]),
      .tok_i    (chain[i]),
      .tok_o    (chain[i+1])
    );

    assign pend_v[i] = chain[i+1].valid;
  end

  assign tail = chain[MAX_INTERFACES];

  // Only one lookup is ever in the row; once it reaches the last cell its
  // result is on the outputs and a new transaction may enter.
  assign busy = (|pend_v) && !pend_v[MAX_INTERFACES-1];

  assign count_d = (ins_accept && ins_ok) ? count_q + CntW'(1) : count_q;

  always_comb begin
    if (ins_ok) begin
      ins_slot_d   = lprt_pkg::SlotW'(count_q);
      ins_len_d    = wr.len;
      ins_status_d = lprt_pkg::STATUS_OK;
    end else begin
      ins_slot_d   = '0;
      ins_len_d    = '0;
      ins_status_d = lprt_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ins_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ins_valid_q <= ins_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_accept) begin
      ins_slot_q   <= ins_slot_d;
      ins_len_q    <= ins_len_d;
      ins_status_q <= ins_status_d;
    end
  end

  // Insert results and lookup results never fall in the same cycle.
  always_comb begin
    done_o          = ins_valid_q || tail.valid;
    matched_o       = 1'b0;
    slot_o          = '0;
    prefix_length_o = '0;
    status_o        = lprt_pkg::STATUS_OK;
    if (ins_valid_q) begin
      slot_o          = ins_slot_q;
      prefix_length_o = ins_len_q;
      status_o        = ins_status_q;
    end else if (tail.valid) begin
      matched_o       = tail.found;
      slot_o          = tail.slot;
      prefix_length_o = tail.len;
    end
  end

`ifndef ASSERT_OFF
  a_one_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pend_v))
    else $error("more than one lookup inside the cell row");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_valid_q && tail.valid))
    else $error("insert and lookup results collide");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count beyond table depth");

  a_lookup_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == lprt_pkg::MODE_LOOKUP)) |=> pend_v[0])
    else $error("accepted lookup did not enter the first cell");
`endif

endmodule

// File: dv/longest_prefix_route_table_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the longest prefix route table. A driver pushes
// insert and lookup transactions from a queue of pending commands, a local
// route table model predicts every result at acceptance, and a monitor
// compares each done_o strobe against the oldest prediction.
module longest_prefix_route_table_core_tb;

  localparam int unsigned MaxIfc      = 8;
  localparam int unsigned RandItems   = 400;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 2 * MaxIfc + 4;

  typedef struct {
    logic                       mode;
    logic [lprt_pkg::AddrW-1:0] addr;
    logic [lprt_pkg::AddrW-1:0] mask;
    bit                         hold;   // launch only once every result has come back
    int unsigned                phase;
  } route_cmd_t;

  typedef struct {
    logic                       matched;
    logic [lprt_pkg::SlotW-1:0] slot;
    logic [lprt_pkg::LenW-1:0]  len;
    logic                       status;
  } route_result_t;

  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       start     = 1'b0;
  logic                       mode_i    = lprt_pkg::MODE_INSERT;
  logic [31:0]                address_i = '0;
  logic [31:0]                mask_i    = '0;
  logic                       busy;
  logic                       done_o;
  logic                       matched_o;
  logic [lprt_pkg::SlotW-1:0] slot_o;
  logic [lprt_pkg::LenW-1:0]  prefix_length_o;
  logic                       status_o;

  route_cmd_t        pending_q[$];
  route_result_t     expected_q[$];

  // Predictor copy of the route table.
  logic [lprt_pkg::AddrW-1:0] rt_addr[MaxIfc];
  logic [lprt_pkg::AddrW-1:0] rt_mask[MaxIfc];
  int unsigned                rt_count = 0;

  // Entries the stimulus expects to land in the table, used to aim lookups.
  logic [lprt_pkg::AddrW-1:0] plan_addr[MaxIfc];
  logic [lprt_pkg::AddrW-1:0] plan_mask[MaxIfc];
  int unsigned                plan_count = 0;

  int unsigned       err_count = 0;
  int unsigned       n_insert = 0;
  int unsigned       n_full = 0;
  int unsigned       n_lookup = 0;
  int unsigned       n_hit = 0;
  int unsigned       n_checked = 0;
  int unsigned       cycles = 0;

  longest_prefix_route_table_core #(
    .MAX_INTERFACES(MaxIfc)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .address_i      (address_i),
    .mask_i         (mask_i),
    .done_o         (done_o),
    .matched_o      (matched_o),
    .slot_o         (slot_o),
    .prefix_length_o(prefix_length_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Applies one command to the predictor table and returns its result.
  function automatic route_result_t route_apply(logic mode,
                                                logic [lprt_pkg::AddrW-1:0] addr,
                                                logic [lprt_pkg::AddrW-1:0] mask);
    route_result_t r;
    int unsigned   best_len;
    int unsigned   len;
    r.matched = 1'b0;
    r.slot    = '0;
    r.len     = '0;
    r.status  = lprt_pkg::STATUS_OK;
    best_len  = 0;
    if (mode == lprt_pkg::MODE_INSERT) begin
      if (rt_count < MaxIfc) begin
        rt_addr[rt_count] = addr;
        rt_mask[rt_count] = mask;
        r.slot = rt_count[lprt_pkg::SlotW-1:0];
        r.len  = lprt_pkg::LenW'($countones(mask));
        rt_count++;
        n_insert++;
      end else begin
        r.status = lprt_pkg::STATUS_FULL;
        n_full++;
      end
    end else begin
      n_lookup++;
      for (int i = 0; i < rt_count; i++) begin
        if (((addr ^ rt_addr[i]) & rt_mask[i]) == '0) begin
          len = $countones(rt_mask[i]);
          // Only a strictly longer prefix displaces the earlier entry.
          if (!r.matched || len > best_len) begin
            r.matched = 1'b1;
            r.slot    = i[lprt_pkg::SlotW-1:0];
            best_len  = len;
          end
        end
      end
      r.len = best_len[lprt_pkg::LenW-1:0];
      if (r.matched) n_hit++;
    end
    return r;
  endfunction

  // Sender idle rate per phase. The receiver cannot hold results off, so the
  // receiver-stall phase runs with no sender gaps.
  function automatic int unsigned idle_pct(int unsigned phase);
    case (phase)
      1:       return 83;
      3:       return 11;
      default: return 0;
    endcase
  endfunction

  task automatic queue_cmd(logic mode, logic [lprt_pkg::AddrW-1:0] addr,
                           logic [lprt_pkg::AddrW-1:0] mask,
                           int unsigned phase, bit hold = 1'b0);
    route_cmd_t c;
    c.mode  = mode;
    c.addr  = addr;
    c.mask  = mask;
    c.hold  = hold;
    c.phase = phase;
    pending_q.push_back(c);
    if (mode == lprt_pkg::MODE_INSERT && plan_count < MaxIfc) begin
      plan_addr[plan_count] = addr;
      plan_mask[plan_count] = mask;
      plan_count++;
    end
  endtask

  // Driver: a transaction is taken when start is high and busy is low at the
  // edge; the next command is launched in that same edge.
  always @(posedge clk_i) begin : drv
    logic       take;
    logic       launch;
    route_cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) expected_q.push_back(route_apply(mode_i, address_i, mask_i));
      if (!start || take) begin
        launch = 1'b0;
        if (pending_q.size() > 0) begin
          nxt    = pending_q[0];
          launch = !(nxt.hold && expected_q.size() > 0) &&
                   ($urandom_range(99) >= idle_pct(nxt.phase));
        end
        if (launch) begin
          nxt = pending_q.pop_front();
          start     <= 1'b1;
          mode_i    <= nxt.mode;
          address_i <= nxt.addr;
          mask_i    <= nxt.mask;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobe is taken at the edge that ends its cycle.
  always @(posedge clk_i) begin : mon
    route_result_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with none pending: matched=%0b slot=%0d len=%0d st=%0b",
                                  matched_o, slot_o, prefix_length_o, status_o));
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (matched_o !== want.matched)
          report_mismatch($sformatf("matched %0b, expected %0b", matched_o, want.matched));
        if (slot_o !== want.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", slot_o, want.slot));
        if (prefix_length_o !== want.len)
          report_mismatch($sformatf("prefix_length %0d, expected %0d",
                                    prefix_length_o, want.len));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b", status_o, want.status));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycles, expected_q.size());
      $display("longest_prefix_route_table_core_tb: FAIL");
      $finish;
    end
  end

  initial begin : stim
    int unsigned                phase;
    int unsigned                pick;
    int unsigned                k;
    logic [lprt_pkg::AddrW-1:0] addr;
    logic [lprt_pkg::AddrW-1:0] mask;
    logic [lprt_pkg::AddrW-1:0] dest;

    // Empty table: nothing can match.
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    // Nested prefixes, a non-contiguous mask that ties a contiguous one, and
    // two host routes, one at the top of the address range.
    queue_cmd(lprt_pkg::MODE_INSERT, 32'h0A00_0000, 32'hFF00_0000, 0);
    queue_cmd(lprt_pkg::MODE_INSERT, 32'h0A01_0000, 32'hFFFF_0000, 0);
    queue_cmd(lprt_pkg::MODE_INSERT, 32'h0A01_0200, 32'hFF00_FF00, 0);
    queue_cmd(lprt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_cmd(lprt_pkg::MODE_INSERT, 32'hC0A8_0001, 32'hFFFF_FFFF, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h0A01_0203, 32'h0000_0000, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h0A7F_0000, 32'hFFFF_FFFF, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h0B00_0000, 32'h0000_0000, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    // Duplicate of the first route, a zero netmask that matches everything,
    // and a sparse mask; this fills the table.
    queue_cmd(lprt_pkg::MODE_INSERT, 32'h0A00_0000, 32'hFF00_0000, 0);
    queue_cmd(lprt_pkg::MODE_INSERT, 32'h1234_5678, 32'h0000_0000, 0);
    queue_cmd(lprt_pkg::MODE_INSERT, 32'h8000_0001, 32'h8000_0001, 0);
    // Inserts into the full table are rejected.
    queue_cmd(lprt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_cmd(lprt_pkg::MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h0B00_0000, 32'h0000_0000, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h8000_0001, 32'h0000_0000, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h0A00_0005, 32'h0000_0000, 0);
    queue_cmd(lprt_pkg::MODE_LOOKUP, 32'h0A01_0203, 32'hFFFF_FFFF, 0);

    // Random part in four idling phases. Most lookups are aimed at a stored
    // route with random host bits, some with one random bit flipped so they may miss it.
    for (int n = 0; n < RandItems; n++) begin
      phase = n / (RandItems / 4);
      pick  = $urandom_range(99);
      addr  = $urandom();
      mask  = $urandom();
      if (pick < 8) begin
        queue_cmd(lprt_pkg::MODE_INSERT, addr, mask, phase, (n % 100) == 0);
      end else if (pick < 20) begin
        queue_cmd(lprt_pkg::MODE_LOOKUP, addr, mask, phase, (n % 100) == 0);
      end else begin
        k    = $urandom_range(plan_count - 1);
        dest = (plan_addr[k] & plan_mask[k]) | (addr & ~plan_mask[k]);
        if (pick < 35) dest = dest ^ (32'h1 << $urandom_range(31));
        queue_cmd(lprt_pkg::MODE_LOOKUP, dest, mask, phase, (n % 100) == 0);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d accepted inserts, %0d inserts into a full table, %0d lookups",
             n_insert, n_full, n_lookup);
    $display("(%0d matched), %0d results checked, %0d mismatches.",
             n_hit, n_checked, err_count);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("longest_prefix_route_table_core_tb: PASS");
    end else begin
      $display("longest_prefix_route_table_core_tb: FAIL");
    end
    $finish;
  end

endmodule
